// ===== rtl/rltc_pkg.sv =====
// shared codes, widths and controller/datapath interface types for the redo log controller
package rltc_pkg;

  localparam int COUNT_W = 5;

  // operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WAIT      = 3'd1;
  localparam logic [2:0] ST_TOO_BIG   = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  // disk command codes
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_COPY   = 2'd1;
  localparam logic [1:0] CMD_HEADER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LOG_START = 2'd0;
  localparam logic [1:0] REG_LOG_AREA  = 2'd1;
  localparam logic [1:0] REG_DEVICE    = 2'd2;

  // kind of result the datapath loads into its output registers
  localparam logic [2:0] EMIT_NONE     = 3'd0;
  localparam logic [2:0] EMIT_STATUS   = 3'd1;
  localparam logic [2:0] EMIT_COPY_OUT = 3'd2;
  localparam logic [2:0] EMIT_HDR_FULL = 3'd3;
  localparam logic [2:0] EMIT_COPY_IN  = 3'd4;
  localparam logic [2:0] EMIT_HDR_ZERO = 3'd5;

  typedef struct packed {
    logic [2:0] emit;
    logic [2:0] emit_status;
    logic       emit_absorbed;
    logic       emit_last;
    logic       open_inc;
    logic       open_dec;
    logic       latch_blk;
    logic       idx_clr;
    logic       step;
    logic       append;
    logic       count_clr;
  } rltc_cmd_t;

  typedef struct packed {
    logic open_zero;
    logic open_one;
    logic count_zero;
    logic begin_room;
    logic write_full;
    logic rd_valid;
    logic rd_match;
    logic idx_end;
  } rltc_sts_t;

endpackage

// ===== rtl/rltc_ctrl.sv =====
// controller state machine of the redo log controller
module rltc_ctrl import rltc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  rltc_sts_t  sts,
  output rltc_cmd_t  cmd,
  output logic       busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_COPY    = 3'd2;
  localparam logic [2:0] S_HDR1    = 3'd3;
  localparam logic [2:0] S_INSTALL = 3'd4;
  localparam logic [2:0] S_HDR2    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.emit_last = 1'b1;
          unique case (operation)
            OP_BEGIN: begin
              cmd.emit        = EMIT_STATUS;
              cmd.emit_status = sts.begin_room ? ST_OK : ST_WAIT;
              cmd.open_inc    = sts.begin_room;
            end
            OP_END: begin
              if (sts.open_zero) begin
                cmd.emit        = EMIT_STATUS;
                cmd.emit_status = ST_UNDERFLOW;
              end else begin
                cmd.open_dec = 1'b1;
                if (sts.open_one && !sts.count_zero) begin
                  // last end of the group: run the commit sequence
                  cmd.emit_last = 1'b0;
                  cmd.idx_clr   = 1'b1;
                  state_next    = S_COPY;
                end else begin
                  cmd.emit        = EMIT_STATUS;
                  cmd.emit_status = ST_OK;
                end
              end
            end
            OP_WRITE: begin
              if (sts.write_full) begin
                cmd.emit        = EMIT_STATUS;
                cmd.emit_status = ST_TOO_BIG;
              end else if (sts.open_zero) begin
                cmd.emit        = EMIT_STATUS;
                cmd.emit_status = ST_OUTSIDE;
              end else begin
                cmd.emit_last = 1'b0;
                cmd.latch_blk = 1'b1;
                cmd.idx_clr   = 1'b1;
                state_next    = S_SEARCH;
              end
            end
            default: begin
              cmd.emit        = EMIT_STATUS;
              cmd.emit_status = ST_OK;
            end
          endcase
        end
      end
      S_SEARCH: begin
        cmd.step        = 1'b1;
        cmd.emit_status = ST_OK;
        cmd.emit_last   = 1'b1;
        if (sts.rd_match) begin
          cmd.emit          = EMIT_STATUS;
          cmd.emit_absorbed = 1'b1;
          state_next        = S_IDLE;
        end else if (sts.idx_end) begin
          cmd.emit   = EMIT_STATUS;
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.step = 1'b1;
        if (sts.rd_valid) begin
          cmd.emit = EMIT_COPY_OUT;
          if (sts.idx_end) begin
            state_next = S_HDR1;
          end
        end
      end
      S_HDR1: begin
        cmd.emit    = EMIT_HDR_FULL;
        cmd.idx_clr = 1'b1;
        state_next  = S_INSTALL;
      end
      S_INSTALL: begin
        cmd.step = 1'b1;
        if (sts.rd_valid) begin
          cmd.emit = EMIT_COPY_IN;
          if (sts.idx_end) begin
            state_next = S_HDR2;
          end
        end
      end
      S_HDR2: begin
        cmd.emit      = EMIT_HDR_ZERO;
        cmd.emit_last = 1'b1;
        cmd.count_clr = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rltc_datapath.sv =====
// datapath of the redo log controller: block table, counters, config and result registers
module rltc_datapath import rltc_pkg::*; #(
  parameter int LOG_ENTRIES       = 30,
  parameter int MAX_BLOCKS_PER_OP = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic [31:0] block_number,
  input  rltc_cmd_t   cmd,
  output rltc_sts_t   sts,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [1:0]  command,
  output logic [31:0] source_block,
  output logic [31:0] dest_block,
  output logic [4:0]  header_count,
  output logic [7:0]  device,
  output logic        absorbed,
  output logic        last
);

  localparam int AW = $clog2(LOG_ENTRIES);

  logic [31:0]        log_start;
  logic [15:0]        log_area_blocks;
  logic [7:0]         device_id;
  logic [31:0]        entries [LOG_ENTRIES];
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] open_ops;
  logic [COUNT_W-1:0] idx;
  logic [31:0]        blk;
  logic [31:0]        rdata;
  logic               rd_valid;
  logic [10:0]        need;
  logic               idx_below;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log_start       <= 32'd2;
      log_area_blocks <= 16'd31;
      device_id       <= 8'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LOG_START: log_start       <= wr_data;
        REG_LOG_AREA:  log_area_blocks <= wr_data[15:0];
        REG_DEVICE:    device_id       <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // space reserved by open operations, counting the new one
  assign need = 11'(entry_count) + 11'({1'b0, open_ops} + 6'd1) * 11'(MAX_BLOCKS_PER_OP);
  assign idx_below = (idx < entry_count);

  always_comb begin
    sts.open_zero  = (open_ops == '0);
    sts.open_one   = (open_ops == COUNT_W'(1));
    sts.count_zero = (entry_count == '0);
    sts.begin_room = (need <= 11'(LOG_ENTRIES));
    sts.write_full = (entry_count >= COUNT_W'(LOG_ENTRIES)) ||
                     ((17'(entry_count) + 17'd1) >= 17'(log_area_blocks));
    sts.rd_valid   = rd_valid;
    sts.rd_match   = rd_valid && (rdata == blk);
    sts.idx_end    = (idx == entry_count);
  end

  // counters and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      open_ops    <= '0;
      idx         <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (cmd.open_inc) begin
        open_ops <= open_ops + COUNT_W'(1);
      end else if (cmd.open_dec) begin
        open_ops <= open_ops - COUNT_W'(1);
      end
      if (cmd.count_clr) begin
        entry_count <= '0;
      end else if (cmd.append) begin
        entry_count <= entry_count + COUNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.step) begin
        rd_valid <= idx_below;
        if (idx_below) begin
          idx <= idx + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_blk) begin
      blk <= block_number;
    end
  end

  // block table
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      entries[entry_count[AW-1:0]] <= blk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && idx_below) begin
      rdata <= entries[idx[AW-1:0]];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      last <= cmd.emit_last;
      unique case (cmd.emit)
        EMIT_STATUS: begin
          status       <= cmd.emit_status;
          command      <= CMD_NONE;
          source_block <= '0;
          dest_block   <= '0;
          header_count <= '0;
          device       <= '0;
          absorbed     <= cmd.emit_absorbed;
        end
        EMIT_COPY_OUT: begin
          status       <= ST_OK;
          command      <= CMD_COPY;
          source_block <= rdata;
          dest_block   <= log_start + 32'(idx);
          header_count <= '0;
          device       <= device_id;
          absorbed     <= 1'b0;
        end
        EMIT_HDR_FULL: begin
          status       <= ST_OK;
          command      <= CMD_HEADER;
          source_block <= '0;
          dest_block   <= log_start;
          header_count <= entry_count;
          device       <= device_id;
          absorbed     <= 1'b0;
        end
        EMIT_COPY_IN: begin
          status       <= ST_OK;
          command      <= CMD_COPY;
          source_block <= log_start + 32'(idx);
          dest_block   <= rdata;
          header_count <= '0;
          device       <= device_id;
          absorbed     <= 1'b0;
        end
        default: begin
          status       <= ST_OK;
          command      <= CMD_HEADER;
          source_block <= '0;
          dest_block   <= log_start;
          header_count <= '0;
          device       <= device_id;
          absorbed     <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(LOG_ENTRIES))
    else $error("entry count beyond table depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (entry_count < COUNT_W'(LOG_ENTRIES)) && (open_ops != '0))
    else $error("append into full table or outside an operation");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (idx <= entry_count))
    else $error("scan index past entry count");

  a_commit_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_HDR_ZERO) |=> (entry_count == '0) && result_valid && last)
    else $error("commit did not empty the table");
`endif

endmodule

// ===== rtl/redo_log_transaction_controller_top.sv =====
// top level of the group-commit redo log controller
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  item in   | start, busy            | operation, block_number
//  result    | result_valid (strobe)  | status, command, source_block, dest_block,
//            |                        | header_count, device, absorbed, last
//  config    | wr_en                  | wr_index, wr_data
//
// an item is taken when start is high and busy is low; its results follow at most one per cycle
// begin, rejected writes and an end that does not start a commit: one result, the cycle after the item is taken
// block write: a scan of the table, one entry per cycle, that absorbs the block if found or else appends it
// commit: one copy per cycle through the table's single read port
// rst is synchronous and active high; the table itself is never cleared, only its count
// the receiver cannot stall: each result shows for one cycle with result_valid high
module redo_log_transaction_controller_top import rltc_pkg::*; #(
  parameter int LOG_ENTRIES       = 30,
  parameter int MAX_BLOCKS_PER_OP = 10
) (
  input  logic        clk,
  input  logic        rst,
  // item in
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] block_number,
  // config
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  // result
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [1:0]  command,
  output logic [31:0] source_block,
  output logic [31:0] dest_block,
  output logic [4:0]  header_count,
  output logic [7:0]  device,
  output logic        absorbed,
  output logic        last
);

  rltc_cmd_t cmd;
  rltc_sts_t sts;

  // sequencing: admission, search and commit phases
  rltc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // table, counters, config registers and result registers
  rltc_datapath #(
    .LOG_ENTRIES       (LOG_ENTRIES),
    .MAX_BLOCKS_PER_OP (MAX_BLOCKS_PER_OP)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .block_number (block_number),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .status       (status),
    .command      (command),
    .source_block (source_block),
    .dest_block   (dest_block),
    .header_count (header_count),
    .device       (device),
    .absorbed     (absorbed),
    .last         (last)
  );

endmodule
